### src/tfbi_pkg.sv
// Package for the tangent field barycentric interpolator.
// Holds payload structs, sequencer states, unit command struct and helper functions.
// No dependencies.
`default_nettype none
package tfbi_pkg;

    localparam int OUT_FRAC_BITS_DEF = 12;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W  = 40;
    localparam int CMAG_W = 32;
    localparam int MAG_W  = 17;
    localparam int M_W    = 30;
    localparam int K_W    = 4;
    localparam int R_W    = 26;
    localparam int ROOT_W = 32;

    typedef struct packed {
        logic        [15:0] weight;
        logic signed [15:0] tangent_u;
        logic signed [15:0] tangent_v;
        logic signed [15:0] first_axis_x;
        logic signed [15:0] first_axis_y;
        logic signed [15:0] first_axis_z;
        logic signed [15:0] second_axis_x;
        logic signed [15:0] second_axis_y;
        logic signed [15:0] second_axis_z;
        logic               pass_through;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } out_item_t;

    // Command to the shared root / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } ru_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_U,
        ST_MUL_V,
        ST_ADD_C,
        ST_PASS,
        ST_SQ,
        ST_SQ_ACC,
        ST_ROOT1_GO,
        ST_ROOT1,
        ST_WC,
        ST_WC_ACC,
        ST_WL,
        ST_WL_ACC,
        ST_SCALE,
        ST_MM,
        ST_MM_ACC,
        ST_ROOT2_GO,
        ST_ROOT2,
        ST_CMP,
        ST_NMUL,
        ST_NDIV_GO,
        ST_NDIV,
        ST_UMUL,
        ST_UACC,
        ST_OUT
    } state_t;

    // Magnitude of a 16-bit two's complement value
    function automatic logic [MAG_W-1:0] mag16(input logic [15:0] x);
        logic [MAG_W-1:0] e;
        e = {x[15], x};
        return x[15] ? MAG_W'(~e + 1'b1) : e;
    endfunction

    // Apply sign to a magnitude and saturate to 16 bits
    function automatic logic [15:0] sat16(input logic neg, input logic [PROD_W-1:0] m);
        logic [15:0] r;
        if (neg) begin
            if (m > PROD_W'(32768)) r = 16'h8000;
            else                    r = 16'(~m[15:0] + 16'd1);
        end else begin
            if (m > PROD_W'(32767)) r = 16'h7fff;
            else                    r = m[15:0];
        end
        return r;
    endfunction

    // Saturating signed accumulate of a signed magnitude
    function automatic logic signed [SUM_W-1:0] acc_sat(input logic signed [SUM_W-1:0] s,
                                                       input logic neg,
                                                       input logic [PROD_W-1:0] m);
        logic signed [49:0] se;
        logic signed [49:0] ad;
        logic signed [49:0] t;
        logic signed [SUM_W-1:0] r;
        se = 50'(s);
        ad = $signed({2'b00, m[47:0]});
        t  = neg ? se - ad : se + ad;
        if (t[49:SUM_W-1] == '0 || t[49:SUM_W-1] == '1) r = t[SUM_W-1:0];
        else if (t[49]) r = {1'b1, {(SUM_W-1){1'b0}}};
        else            r = {1'b0, {(SUM_W-1){1'b1}}};
        return r;
    endfunction

endpackage
`default_nettype wire

### src/tangent_field_barycentric_interp.sv
// Processing time of an ordinary item is set mostly by the 32-step square root.
// A last item adds a scaling pass and a second root, then each output component goes through
// the 64-step divider when the sum is normalized, or a multiply otherwise.
// One item at a time: s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) clears the sums, min_length, sequencer and output valid.
// Depends on tfbi_pkg, tfbi_mul and tfbi_root_div.
`default_nettype none
module tangent_field_barycentric_interp #(
    parameter int OUT_FRAC_BITS = tfbi_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tfbi_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tfbi_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data
);

    localparam int SH = 26 - OUT_FRAC_BITS;

    tfbi_pkg::state_t state_reg, state_next;

    tfbi_pkg::in_item_t                  item_reg;
    logic [1:0]                          idx_reg;
    logic signed [33:0]                  t_reg;
    logic [tfbi_pkg::CMAG_W-1:0]         cmag_reg [3];
    logic                                cneg_reg [3];
    logic [tfbi_pkg::PROD_W-1:0]         acc_reg;
    logic [tfbi_pkg::ROOT_W-1:0]         len_reg;
    logic signed [tfbi_pkg::SUM_W-1:0]   sum_reg [3];
    logic [tfbi_pkg::SUM_W-1:0]          suml_reg;
    logic [tfbi_pkg::R_W-1:0]            r_reg;
    logic [tfbi_pkg::K_W-1:0]            k_reg;
    logic [tfbi_pkg::M_W-1:0]            m_reg [3];
    logic [tfbi_pkg::ROOT_W-1:0]         n_reg;
    logic                                norm_reg;
    logic [15:0]                         res_reg [3];
    logic [15:0]                         min_len_reg;
    tfbi_pkg::out_item_t                 m_data_reg;
    logic                                m_valid_reg;

    logic [tfbi_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [tfbi_pkg::PROD_W-1:0] mul_p;
    tfbi_pkg::ru_cmd_t           ru_cmd;
    logic [tfbi_pkg::PROD_W-1:0] ru_a;
    logic                        ru_done;
    logic [tfbi_pkg::PROD_W-1:0] ru_res;

    logic [15:0]              axis_a, axis_b;
    logic                     s1_neg, s2_neg;
    logic signed [33:0]       t_sum, p1_s, p2_s;
    logic [32:0]              t_mag;
    logic [tfbi_pkg::CMAG_W-1:0] c_new;
    logic [tfbi_pkg::SUM_W-1:0]  smag [3];
    logic [tfbi_pkg::SUM_W-1:0]  smag_or;
    logic [tfbi_pkg::K_W-1:0]    k_calc;
    logic [tfbi_pkg::R_W-1:0]    sq_mag;
    logic [40:0]                 suml_rnd;
    logic [48:0]                 suml_add;
    logic [41:0]                 n_sh, min_sh;
    logic [tfbi_pkg::PROD_W-1:0] uq;
    logic                        out_load;

    tfbi_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    tfbi_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ru_cmd),
        .opa     (ru_a),
        .opb     (n_reg),
        .done    (ru_done),
        .result  (ru_res)
    );

    // Select the basis components for the current axis
    always_comb begin
        case (idx_reg)
            2'd0:    begin axis_a = item_reg.first_axis_x; axis_b = item_reg.second_axis_x; end
            2'd1:    begin axis_a = item_reg.first_axis_y; axis_b = item_reg.second_axis_y; end
            2'd2:    begin axis_a = item_reg.first_axis_z; axis_b = item_reg.second_axis_z; end
            default: begin axis_a = item_reg.first_axis_x; axis_b = item_reg.second_axis_x; end
        endcase
        s1_neg = item_reg.tangent_u[15] ^ axis_a[15];
        s2_neg = item_reg.tangent_v[15] ^ axis_b[15];
    end

    // Combine the two products and round to output fraction bits
    always_comb begin
        p1_s  = $signed({2'b00, mul_p[31:0]});
        p2_s  = s2_neg ? -$signed({2'b00, mul_p[31:0]}) : $signed({2'b00, mul_p[31:0]});
        p1_s  = s1_neg ? -p1_s : p1_s;
        t_sum = t_reg + p2_s;
        t_mag = t_sum[33] ? 33'(-t_sum) : t_sum[32:0];
        c_new = tfbi_pkg::CMAG_W'((34'(t_mag) + (34'd1 << (SH - 1))) >> SH);
    end

    // Scale search over the summed vector, plus the roundings, sums and shifts used by later steps
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            smag[i] = sum_reg[i][tfbi_pkg::SUM_W-1] ? tfbi_pkg::SUM_W'(-sum_reg[i])
                                                    : tfbi_pkg::SUM_W'(sum_reg[i]);
        end
        smag_or = smag[0] | smag[1] | smag[2];
        k_calc  = '0;
        for (int b = 30; b < tfbi_pkg::SUM_W; b++) begin
            if (smag_or[b]) k_calc = tfbi_pkg::K_W'(b - 29);
        end
        suml_rnd = 41'(suml_reg) + 41'd16384;
        suml_add = 49'(suml_reg) + mul_p[48:0];
        sq_mag   = tfbi_pkg::R_W'((41'(smag[idx_reg]) + 41'd16384) >> 15);
        n_sh     = 42'(n_reg) << k_reg;
        min_sh   = 42'(min_len_reg) << 15;
        uq       = (mul_p + (tfbi_pkg::PROD_W'(1) << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS;
    end

    // Multiplier operands for each step
    always_comb begin
        case (state_reg)
            tfbi_pkg::ST_MUL_U: begin
                mul_a = 32'(tfbi_pkg::mag16(item_reg.tangent_u));
                mul_b = 32'(tfbi_pkg::mag16(axis_a));
            end
            tfbi_pkg::ST_MUL_V: begin
                mul_a = 32'(tfbi_pkg::mag16(item_reg.tangent_v));
                mul_b = 32'(tfbi_pkg::mag16(axis_b));
            end
            tfbi_pkg::ST_SQ: begin
                mul_a = cmag_reg[idx_reg];
                mul_b = cmag_reg[idx_reg];
            end
            tfbi_pkg::ST_WC: begin
                mul_a = 32'(item_reg.weight);
                mul_b = cmag_reg[idx_reg];
            end
            tfbi_pkg::ST_WL: begin
                mul_a = 32'(item_reg.weight);
                mul_b = len_reg;
            end
            tfbi_pkg::ST_MM: begin
                mul_a = 32'(m_reg[idx_reg]);
                mul_b = 32'(m_reg[idx_reg]);
            end
            tfbi_pkg::ST_NMUL: begin
                mul_a = 32'(r_reg);
                mul_b = 32'(m_reg[idx_reg]);
            end
            tfbi_pkg::ST_UMUL: begin
                mul_a = 32'(r_reg);
                mul_b = 32'(sq_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Root / divide unit commands
    always_comb begin
        ru_cmd.start  = 1'b0;
        ru_cmd.is_div = 1'b0;
        ru_a          = acc_reg;
        case (state_reg)
            tfbi_pkg::ST_ROOT1_GO, tfbi_pkg::ST_ROOT2_GO: ru_cmd.start = 1'b1;
            tfbi_pkg::ST_NDIV_GO: begin
                ru_cmd.start  = 1'b1;
                ru_cmd.is_div = 1'b1;
                ru_a          = mul_p + tfbi_pkg::PROD_W'(n_reg >> 1);
            end
            default: ru_cmd.start = 1'b0;
        endcase
    end

    assign out_load = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfbi_pkg::ST_IDLE:     if (s_valid) state_next = tfbi_pkg::ST_MUL_U;
            tfbi_pkg::ST_MUL_U:    state_next = tfbi_pkg::ST_MUL_V;
            tfbi_pkg::ST_MUL_V:    state_next = tfbi_pkg::ST_ADD_C;
            tfbi_pkg::ST_ADD_C: begin
                if (idx_reg != 2'd2)             state_next = tfbi_pkg::ST_MUL_U;
                else if (item_reg.pass_through)  state_next = tfbi_pkg::ST_PASS;
                else                             state_next = tfbi_pkg::ST_SQ;
            end
            tfbi_pkg::ST_PASS:     state_next = tfbi_pkg::ST_OUT;
            tfbi_pkg::ST_SQ:       state_next = tfbi_pkg::ST_SQ_ACC;
            tfbi_pkg::ST_SQ_ACC:
                state_next = (idx_reg == 2'd2) ? tfbi_pkg::ST_ROOT1_GO : tfbi_pkg::ST_SQ;
            tfbi_pkg::ST_ROOT1_GO: state_next = tfbi_pkg::ST_ROOT1;
            tfbi_pkg::ST_ROOT1:    if (ru_done) state_next = tfbi_pkg::ST_WC;
            tfbi_pkg::ST_WC:       state_next = tfbi_pkg::ST_WC_ACC;
            tfbi_pkg::ST_WC_ACC:
                state_next = (idx_reg == 2'd2) ? tfbi_pkg::ST_WL : tfbi_pkg::ST_WC;
            tfbi_pkg::ST_WL:       state_next = tfbi_pkg::ST_WL_ACC;
            tfbi_pkg::ST_WL_ACC:
                state_next = item_reg.last_item ? tfbi_pkg::ST_SCALE : tfbi_pkg::ST_IDLE;
            tfbi_pkg::ST_SCALE:    state_next = tfbi_pkg::ST_MM;
            tfbi_pkg::ST_MM:       state_next = tfbi_pkg::ST_MM_ACC;
            tfbi_pkg::ST_MM_ACC:
                state_next = (idx_reg == 2'd2) ? tfbi_pkg::ST_ROOT2_GO : tfbi_pkg::ST_MM;
            tfbi_pkg::ST_ROOT2_GO: state_next = tfbi_pkg::ST_ROOT2;
            tfbi_pkg::ST_ROOT2:    if (ru_done) state_next = tfbi_pkg::ST_CMP;
            tfbi_pkg::ST_CMP:
                state_next = (n_sh > min_sh) ? tfbi_pkg::ST_NMUL : tfbi_pkg::ST_UMUL;
            tfbi_pkg::ST_NMUL:     state_next = tfbi_pkg::ST_NDIV_GO;
            tfbi_pkg::ST_NDIV_GO:  state_next = tfbi_pkg::ST_NDIV;
            tfbi_pkg::ST_NDIV: begin
                if (ru_done)
                    state_next = (idx_reg == 2'd2) ? tfbi_pkg::ST_OUT : tfbi_pkg::ST_NMUL;
            end
            tfbi_pkg::ST_UMUL:     state_next = tfbi_pkg::ST_UACC;
            tfbi_pkg::ST_UACC:
                state_next = (idx_reg == 2'd2) ? tfbi_pkg::ST_OUT : tfbi_pkg::ST_UMUL;
            tfbi_pkg::ST_OUT:      if (out_load) state_next = tfbi_pkg::ST_IDLE;
            default:               state_next = tfbi_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tfbi_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // Control registers: sums, config, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
            suml_reg    <= '0;
            min_len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) min_len_reg <= cfg_data;
            m_valid_reg <= (state_reg == tfbi_pkg::ST_OUT && out_load) ? 1'b1
                                                                        : m_valid_reg & ~m_ready;
            case (state_reg)
                tfbi_pkg::ST_WC_ACC:
                    sum_reg[idx_reg] <= tfbi_pkg::acc_sat(sum_reg[idx_reg],
                                                          cneg_reg[idx_reg], mul_p);
                tfbi_pkg::ST_WL_ACC:
                    suml_reg <= (suml_add[48:40] != '0) ? '1 : suml_add[39:0];
                tfbi_pkg::ST_PASS: begin
                    for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
                    suml_reg <= '0;
                end
                tfbi_pkg::ST_NDIV, tfbi_pkg::ST_UACC: begin
                    if (state_next == tfbi_pkg::ST_OUT) begin
                        for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
                        suml_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            tfbi_pkg::ST_IDLE:
                if (s_valid) begin
                    item_reg <= s_data;
                    idx_reg  <= '0;
                end
            tfbi_pkg::ST_MUL_V: t_reg <= p1_s;
            tfbi_pkg::ST_ADD_C: begin
                cmag_reg[idx_reg] <= c_new;
                cneg_reg[idx_reg] <= t_sum[33];
                idx_reg           <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                acc_reg           <= '0;
            end
            tfbi_pkg::ST_PASS:
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= tfbi_pkg::sat16(cneg_reg[i],
                                                  tfbi_pkg::PROD_W'(cmag_reg[i]));
            tfbi_pkg::ST_SQ_ACC, tfbi_pkg::ST_MM_ACC: begin
                acc_reg <= acc_reg + mul_p;
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            end
            tfbi_pkg::ST_ROOT1: if (ru_done) len_reg <= ru_res[tfbi_pkg::ROOT_W-1:0];
            tfbi_pkg::ST_WC_ACC: idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            tfbi_pkg::ST_SCALE: begin
                r_reg   <= suml_rnd[40:15];
                k_reg   <= k_calc;
                for (int i = 0; i < 3; i++)
                    m_reg[i] <= tfbi_pkg::M_W'(smag[i] >> k_calc);
                acc_reg <= '0;
                idx_reg <= '0;
            end
            tfbi_pkg::ST_ROOT2: if (ru_done) n_reg <= ru_res[tfbi_pkg::ROOT_W-1:0];
            tfbi_pkg::ST_CMP: begin
                norm_reg <= n_sh > min_sh;
                idx_reg  <= '0;
            end
            tfbi_pkg::ST_NDIV:
                if (ru_done) begin
                    res_reg[idx_reg] <= tfbi_pkg::sat16(sum_reg[idx_reg][tfbi_pkg::SUM_W-1],
                                                        ru_res);
                    idx_reg <= idx_reg + 2'd1;
                end
            tfbi_pkg::ST_UACC: begin
                res_reg[idx_reg] <= tfbi_pkg::sat16(sum_reg[idx_reg][tfbi_pkg::SUM_W-1], uq);
                idx_reg          <= idx_reg + 2'd1;
            end
            tfbi_pkg::ST_OUT:
                if (out_load) begin
                    m_data_reg.out_x <= res_reg[0];
                    m_data_reg.out_y <= res_reg[1];
                    m_data_reg.out_z <= res_reg[2];
                end
            default: idx_reg <= idx_reg;
        endcase
    end

    assign s_ready   = (state_reg == tfbi_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == tfbi_pkg::ST_MUL_U)
        else $error("accepted item did not start the sequence");
    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tfbi_pkg::ST_OUT && m_valid && !m_ready |=> state_reg == tfbi_pkg::ST_OUT)
        else $error("result overwrote a pending transfer");
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ru_done |-> (state_reg == tfbi_pkg::ST_ROOT1 || state_reg == tfbi_pkg::ST_ROOT2 ||
                     state_reg == tfbi_pkg::ST_NDIV))
        else $error("root/div finished outside a wait state");
    a_sums_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> suml_reg == '0)
        else $error("sums not cleared with result");

    // norm_reg is kept for observation of the chosen branch
    a_norm_has_root: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tfbi_pkg::ST_NMUL |-> norm_reg && n_reg != '0)
        else $error("normalized branch with zero length");

endmodule
`default_nettype wire

### src/tfbi_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on tfbi_pkg for widths.
`default_nettype none
module tfbi_mul (
    input  wire logic                       aclk,
    input  wire logic [tfbi_pkg::MUL_W-1:0] op_a,
    input  wire logic [tfbi_pkg::MUL_W-1:0] op_b,
    output logic      [tfbi_pkg::PROD_W-1:0] prod
);

    logic [tfbi_pkg::PROD_W-1:0] prod_reg;

    // Register the product every cycle
    always_ff @(posedge aclk) begin
        prod_reg <= tfbi_pkg::PROD_W'(op_a) * tfbi_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

### src/tfbi_root_div.sv
// Shared iterative unit: floor square root of a 64-bit value (2 bits a step)
// or 64-by-32 restoring division (1 bit a step). Depends on tfbi_pkg.
`default_nettype none
module tfbi_root_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire tfbi_pkg::ru_cmd_t            cmd,
    input  wire logic [tfbi_pkg::PROD_W-1:0]  opa,
    input  wire logic [tfbi_pkg::ROOT_W-1:0]  opb,
    output logic                              done,
    output logic      [tfbi_pkg::PROD_W-1:0]  result
);

    logic                         busy_reg;
    logic                         mode_reg;
    logic                         done_reg;
    logic [5:0]                   cnt_reg;
    logic [tfbi_pkg::PROD_W-1:0]  x_reg, x_next;
    logic [34:0]                  rem_reg, rem_next;
    logic [tfbi_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [tfbi_pkg::ROOT_W-1:0]  b_reg;
    logic [34:0]                  rem_s, trial;
    logic [32:0]                  rem_d;
    logic                         ge_s, ge_d, last_step;

    // One step of the selected recurrence
    always_comb begin
        rem_s = {rem_reg[32:0], x_reg[63:62]};
        trial = {1'b0, root_reg, 2'b01};
        ge_s  = rem_s >= trial;
        rem_d = {rem_reg[31:0], x_reg[63]};
        ge_d  = rem_d >= {1'b0, b_reg};
        if (mode_reg) begin
            rem_next  = 35'(ge_d ? rem_d - {1'b0, b_reg} : rem_d);
            root_next = root_reg;
            x_next    = {x_reg[62:0], ge_d};
        end else begin
            rem_next  = ge_s ? rem_s - trial : rem_s;
            root_next = {root_reg[30:0], ge_s};
            x_next    = {x_reg[61:0], 2'b00};
        end
        last_step = mode_reg ? (cnt_reg == 6'd63) : (cnt_reg == 6'd31);
    end

    // Control: start, count, finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands or advance one step
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg <= cmd.is_div;
            x_reg    <= opa;
            b_reg    <= opb;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done   = done_reg;
    assign result = mode_reg ? x_reg : tfbi_pkg::PROD_W'(root_reg);

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("root/div done while still busy");
    a_step_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !cmd.start && !last_step |=> busy_reg && cnt_reg == $past(cnt_reg) + 6'd1)
        else $error("root/div counter did not advance");
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !cmd.start && last_step |=> done_reg)
        else $error("root/div missed done");

endmodule
`default_nettype wire
